>>> design/s5rp_pkg.sv
// Shared types and constants for the SOCKS5 request parser.
// No dependencies; used by s5rp_core and socks5_request_parser.
`default_nettype none

package s5rp_pkg;

   // Parser position within the request
   typedef enum logic [2:0] {
      PH_VERSION  = 3'd0,
      PH_COMMAND  = 3'd1,
      PH_RESERVED = 3'd2,
      PH_ATYP     = 3'd3,
      PH_ADDR     = 3'd4,
      PH_NAME_LEN = 3'd5,
      PH_PORT_HI  = 3'd6,
      PH_PORT_LO  = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      ST_MORE  = 2'd0,
      ST_DONE  = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   localparam logic [7:0] SOCKS_VERSION = 8'h05;
   localparam logic [7:0] RSV_BYTE      = 8'h00;
   localparam logic [7:0] CMD_FIRST     = 8'd1;
   localparam logic [7:0] CMD_LAST      = 8'd3;
   localparam logic [7:0] ADDR_IPV4     = 8'd1;
   localparam logic [7:0] ADDR_DOMAIN   = 8'd3;
   localparam logic [7:0] ADDR_IPV6     = 8'd4;
   localparam logic [8:0] IPV4_LEN      = 9'd4;
   localparam logic [8:0] IPV6_LEN      = 9'd16;

   typedef struct packed {
      logic [1:0]  status;
      logic        addr_valid;
      logic [7:0]  addr_byte;
      logic [7:0]  addr_index;
      logic [1:0]  command_code;
      logic [2:0]  addr_kind;
      logic [15:0] dest_port;
      logic [7:0]  name_length;
   } result_type;

endpackage

`default_nettype wire

>>> design/s5rp_core.sv
// Parser state registers and per-byte next-state / result logic.
// Depends on s5rp_pkg.
`default_nettype none

module s5rp_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic                   restart,
   input  wire logic [7:0]             data_byte,
   output s5rp_pkg::result_type        result
);

   s5rp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  count_ff, count_in;
   logic [2:0]  kind_ff, kind_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [7:0]  len_ff, len_in;
   logic [15:0] port_ff, port_in;
   logic        done_ff, done_in;
   logic        err_ff, err_in;
   logic        av;
   logic [7:0]  ai;
   logic [8:0]  target;
   logic [8:0]  count_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= s5rp_pkg::PH_VERSION;
         count_ff <= '0;
         kind_ff  <= '0;
         cmd_ff   <= '0;
         len_ff   <= '0;
         port_ff  <= '0;
         done_ff  <= 1'b0;
         err_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         kind_ff  <= kind_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         port_ff  <= port_in;
         done_ff  <= done_in;
         err_ff   <= err_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      kind_in  = kind_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      port_in  = port_ff;
      done_in  = done_ff;
      err_in   = err_ff;
      av       = 1'b0;
      ai       = '0;
      count_next = {1'b0, count_ff} + 9'd1;
      if (kind_ff == s5rp_pkg::ADDR_IPV4[2:0]) begin
         target = s5rp_pkg::IPV4_LEN;
      end else if (kind_ff == s5rp_pkg::ADDR_IPV6[2:0]) begin
         target = s5rp_pkg::IPV6_LEN;
      end else begin
         target = {1'b0, len_ff};
      end

      if (restart) begin
         phase_in = s5rp_pkg::PH_VERSION;
         count_in = '0;
         kind_in  = '0;
         cmd_in   = '0;
         len_in   = '0;
         port_in  = '0;
         done_in  = 1'b0;
         err_in   = 1'b0;
      end else if (!done_ff && !err_ff) begin
         unique case (phase_ff)
            s5rp_pkg::PH_VERSION: begin
               if (data_byte != s5rp_pkg::SOCKS_VERSION) err_in = 1'b1;
               else phase_in = s5rp_pkg::PH_COMMAND;
            end
            s5rp_pkg::PH_COMMAND: begin
               if (data_byte < s5rp_pkg::CMD_FIRST || data_byte > s5rp_pkg::CMD_LAST) begin
                  err_in = 1'b1;
               end else begin
                  cmd_in   = data_byte[1:0];
                  phase_in = s5rp_pkg::PH_RESERVED;
               end
            end
            s5rp_pkg::PH_RESERVED: begin
               if (data_byte != s5rp_pkg::RSV_BYTE) err_in = 1'b1;
               else phase_in = s5rp_pkg::PH_ATYP;
            end
            s5rp_pkg::PH_ATYP: begin
               if (data_byte == s5rp_pkg::ADDR_IPV4 || data_byte == s5rp_pkg::ADDR_IPV6) begin
                  kind_in  = data_byte[2:0];
                  count_in = '0;
                  phase_in = s5rp_pkg::PH_ADDR;
               end else if (data_byte == s5rp_pkg::ADDR_DOMAIN) begin
                  kind_in  = data_byte[2:0];
                  count_in = '0;
                  phase_in = s5rp_pkg::PH_NAME_LEN;
               end else begin
                  err_in = 1'b1;
               end
            end
            s5rp_pkg::PH_NAME_LEN: begin
               if (data_byte == 8'd0) begin
                  err_in = 1'b1;
               end else begin
                  len_in   = data_byte;
                  count_in = '0;
                  phase_in = s5rp_pkg::PH_ADDR;
               end
            end
            s5rp_pkg::PH_ADDR: begin
               av = 1'b1;
               ai = count_ff;
               if (count_next >= target) begin
                  count_in = '0;
                  phase_in = s5rp_pkg::PH_PORT_HI;
               end else begin
                  count_in = count_next[7:0];
               end
            end
            s5rp_pkg::PH_PORT_HI: begin
               port_in  = {data_byte, 8'd0};
               phase_in = s5rp_pkg::PH_PORT_LO;
            end
            s5rp_pkg::PH_PORT_LO: begin
               port_in = port_ff | {8'd0, data_byte};
               done_in = 1'b1;
            end
         endcase
      end

      if (err_in) result.status = s5rp_pkg::ST_ERROR;
      else if (done_in) result.status = s5rp_pkg::ST_DONE;
      else result.status = s5rp_pkg::ST_MORE;
      result.addr_valid   = av;
      result.addr_byte    = av ? data_byte : 8'd0;
      result.addr_index   = ai;
      result.command_code = cmd_in;
      result.addr_kind    = kind_in;
      result.dest_port    = (done_in && !err_in) ? port_in : 16'd0;
      result.name_length  = (kind_in == s5rp_pkg::ADDR_DOMAIN[2:0]) ? len_in : 8'd0;
   end

endmodule

`default_nettype wire

>>> design/socks5_request_parser.sv
// SOCKS5 request parser top level: input register, parser core, result register.
// Depends on s5rp_pkg and s5rp_core.
`default_nettype none

// Takes one request byte per item and returns one result item per byte.
// Each item is held in the input register and is parsed as it moves into
// the result register; a new item is taken every cycle while results are
// drained. req_stall rises only when both registers are full and rsp_stall
// is high. A restart item clears the parser; done and error stay set until
// one arrives.
module socks5_request_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_restart,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic             rsp_addr_valid,
   output logic [7:0]       rsp_addr_byte,
   output logic [7:0]       rsp_addr_index,
   output logic [1:0]       rsp_command_code,
   output logic [2:0]       rsp_addr_kind,
   output logic [15:0]      rsp_dest_port,
   output logic [7:0]       rsp_name_length
);

   logic                  in_valid_ff, in_valid_in;
   logic                  in_restart_ff;
   logic [7:0]            in_byte_ff;
   logic                  out_valid_ff, out_valid_in;
   s5rp_pkg::result_type  out_ff;
   s5rp_pkg::result_type  result;
   logic                  accept;
   logic                  advance;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      else in_valid_in = in_valid_ff;

      if (advance) out_valid_in = 1'b1;
      else if (!rsp_stall) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_restart_ff <= req_restart;
         in_byte_ff    <= req_data_byte;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   s5rp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .restart   (in_restart_ff),
      .data_byte (in_byte_ff),
      .result    (result)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_ff.status;
   assign rsp_addr_valid   = out_ff.addr_valid;
   assign rsp_addr_byte    = out_ff.addr_byte;
   assign rsp_addr_index   = out_ff.addr_index;
   assign rsp_command_code = out_ff.command_code;
   assign rsp_addr_kind    = out_ff.addr_kind;
   assign rsp_dest_port    = out_ff.dest_port;
   assign rsp_name_length  = out_ff.name_length;

endmodule

`default_nettype wire
